// ===== rtl/spnpuf_pkg.sv =====
// ----------------------------------------------------------------------------
// spnpuf_pkg
// Shared types, constants and functions of the substitution-permutation PUF.
// ----------------------------------------------------------------------------
`default_nettype none

package spnpuf_pkg;

  localparam int NBOX       = 5;   // boxes per table
  localparam int GW         = 5;   // bits per group / box address
  localparam int CHUNK_W    = 25;  // challenge chunk width
  localparam int BOX_W      = 3;   // box_index width
  localparam int SEL_W      = 2;   // table_select width
  localparam int VAL_W      = 5;   // entry_value width
  localparam int CNT_W      = 2;   // chunk counter width
  localparam int FIFO_DEPTH = 4;   // response buffer depth
  localparam int FIFO_AW    = 2;   // response buffer pointer width

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_CHUNK = 1'b1
  } opcode_t;

  typedef enum logic [SEL_W-1:0] {
    TSEL_FIRST  = 2'd0,
    TSEL_SECOND = 2'd1,
    TSEL_FINAL  = 2'd2,
    TSEL_NONE   = 2'd3
  } tsel_t;

  typedef logic [NBOX-1:0][GW-1:0] grp_t;

  // Write request into one box bank.
  typedef struct packed {
    logic             en;
    logic [BOX_W-1:0] box;
    logic [GW-1:0]    idx;
    logic [VAL_W-1:0] data;
  } box_wr_t;

  // Move bit GW*p+b to bit GW*b+p.
  function automatic grp_t transpose5(input grp_t v);
    grp_t r;
    for (int b = 0; b < NBOX; b++) begin
      for (int p = 0; p < GW; p++) begin
        r[b][p] = v[p][b];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/spnpuf_if.sv =====
// ----------------------------------------------------------------------------
// spnpuf_if
// Valid/ready channels of the PUF: item input and response output.
// ----------------------------------------------------------------------------
`default_nettype none

interface spnpuf_in_if;
  import spnpuf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [CHUNK_W-1:0]   chunk;
  logic [SEL_W-1:0]     table_select;
  logic [BOX_W-1:0]     box_index;
  logic [GW-1:0]        entry_index;
  logic [VAL_W-1:0]     entry_value;

  modport source (output valid, opcode, chunk, table_select, box_index, entry_index,
                  entry_value, input ready);
  modport sink   (input valid, opcode, chunk, table_select, box_index, entry_index,
                  entry_value, output ready);
endinterface

interface spnpuf_out_if;
  logic valid;
  logic ready;
  logic response;

  modport source (output valid, response, input ready);
  modport sink   (input valid, response, output ready);
endinterface

`default_nettype wire

// ===== rtl/spn_puf_response_top.sv =====
// ----------------------------------------------------------------------------
// spn_puf_response_top
// Substitution-permutation PUF response generator with loadable box tables.
// ----------------------------------------------------------------------------
// A load item writes one box entry. A challenge chunk walks a four-step
// pipeline: stage-one box read, stage-two box read, output box read on the
// last chunk, parity. No item is taken while a chunk is still in its
// stage-one step; the limit is the loop from the stage-two read data through
// the transpose and the running value into the next chunk's stage-one read
// address. Output valid rises once the last chunk's parity is in the response
// queue. Responses are buffered in a 4-entry queue, so further items keep
// flowing while a response waits to be taken, as long as fewer than four
// responses are owed.
`default_nettype none

module spn_puf_response_top
  import spnpuf_pkg::*;
#(
  parameter int ROUNDS = 4
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  spnpuf_in_if.sink   in_ch,
  spnpuf_out_if.source out_ch
);

  localparam logic [CNT_W:0]   ROUNDS_L = (CNT_W+1)'(ROUNDS);
  localparam logic [FIFO_AW:0] FULL_L   = (FIFO_AW+1)'(FIFO_DEPTH);

  // handshake
  logic in_acc, chunk_acc, load_acc, out_acc;

  // control state
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CHUNK_W-1:0] run_r, run_nxt;
  logic               v1_r, v2_r, v3_r;
  logic               last1_r, last2_r;
  logic [FIFO_AW:0]   pend_r, pend_nxt;

  // response queue
  logic               fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   fcnt_r;

  // datapath
  logic [CNT_W:0]     cnt_inc;
  logic               chunk_last;
  logic [CHUNK_W-1:0] run_fwd;
  grp_t               s1_addr, s2_addr, fin_addr, v_stage;
  grp_t               s1_q, s2_q;
  logic [NBOX-1:0][0:0] fin_q;
  box_wr_t            wr1, wr2, wr3;
  logic               wr_ok;
  logic               push;

  // Block every item while a chunk is still in its stage-one step, and hold off
  // everything when the responses owed fill the response queue.
  assign in_ch.ready = !v1_r && (pend_r != FULL_L);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign chunk_acc   = in_acc && (in_ch.opcode == OP_CHUNK);
  assign load_acc    = in_acc && (in_ch.opcode == OP_LOAD);
  assign out_acc     = out_ch.valid && out_ch.ready;

  // chunk counting happens at transfer time
  assign cnt_inc    = {1'b0, cnt_r} + 1'b1;
  assign chunk_last = (cnt_inc >= ROUNDS_L);
  assign cnt_nxt    = chunk_last ? '0 : cnt_inc[CNT_W-1:0];

  // Stage-two result of the previous chunk, transposed.
  assign v_stage = transpose5(s2_q);

  // Forward the running value the previous chunk is about to leave.
  always_comb begin
    if (v2_r) begin
      run_fwd = last2_r ? '0 : CHUNK_W'(v_stage);
    end else begin
      run_fwd = run_r;
    end
  end

  assign s1_addr  = grp_t'(in_ch.chunk ^ run_fwd);
  assign s2_addr  = transpose5(s1_q);
  assign fin_addr = v_stage;

  // table writes; out-of-range boxes or table select drop the entry
  assign wr_ok = load_acc && (in_ch.box_index < BOX_W'(NBOX));

  always_comb begin
    wr1      = '{en: 1'b0, box: in_ch.box_index, idx: in_ch.entry_index,
                 data: in_ch.entry_value};
    wr2      = wr1;
    wr3      = wr1;
    wr1.en   = wr_ok && (in_ch.table_select == TSEL_FIRST);
    wr2.en   = wr_ok && (in_ch.table_select == TSEL_SECOND);
    wr3.en   = wr_ok && (in_ch.table_select == TSEL_FINAL);
  end

  spnpuf_box_bank #(.W(GW)) u_first (
    .clk     (clk),
    .wr      (wr1),
    .rd_en   (chunk_acc),
    .rd_addr (s1_addr),
    .rd_data (s1_q)
  );

  spnpuf_box_bank #(.W(GW)) u_second (
    .clk     (clk),
    .wr      (wr2),
    .rd_en   (v1_r),
    .rd_addr (s2_addr),
    .rd_data (s2_q)
  );

  spnpuf_box_bank #(.W(1)) u_final (
    .clk     (clk),
    .wr      (wr3),
    .rd_en   (v2_r && last2_r),
    .rd_addr (fin_addr),
    .rd_data (fin_q)
  );

  // running value: take the new value after stage two, clear after the last
  always_comb begin
    run_nxt = run_r;
    if (v2_r) begin
      run_nxt = last2_r ? '0 : CHUNK_W'(v_stage);
    end
  end

  // count responses owed: queued plus in flight
  always_comb begin
    pend_nxt = pend_r;
    priority case ({chunk_acc && chunk_last, out_acc})
      2'b10:   pend_nxt = pend_r + 1'b1;
      2'b01:   pend_nxt = pend_r - 1'b1;
      default: pend_nxt = pend_r;
    endcase
  end

  assign push = v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      run_r   <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      last1_r <= 1'b0;
      last2_r <= 1'b0;
      pend_r  <= '0;
      wp_r    <= '0;
      rp_r    <= '0;
      fcnt_r  <= '0;
    end else begin
      if (chunk_acc) begin
        cnt_r <= cnt_nxt;
      end
      run_r   <= run_nxt;
      v1_r    <= chunk_acc;
      last1_r <= chunk_acc && chunk_last;
      v2_r    <= v1_r;
      last2_r <= last1_r;
      v3_r    <= v2_r && last2_r;
      pend_r  <= pend_nxt;
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (out_acc) begin
        rp_r <= rp_r + 1'b1;
      end
      priority case ({push, out_acc})
        2'b10:   fcnt_r <= fcnt_r + 1'b1;
        2'b01:   fcnt_r <= fcnt_r - 1'b1;
        default: fcnt_r <= fcnt_r;
      endcase
    end
  end

  // queue payload: store the parity of the five output-box bits
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= ^fin_q;
    end
  end

  assign out_ch.valid    = (fcnt_r != '0);
  assign out_ch.response = fifo_r[rp_r];

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_no_chunk_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> !chunk_acc)
    else $error("chunk transfer while stage one busy");

  a_queue_within_owed: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= pend_r)
    else $error("response queue holds more than owed");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (fcnt_r < FULL_L))
    else $error("response pushed into full queue");

  a_last_reaches_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (chunk_acc && chunk_last) |=> ##2 v3_r)
    else $error("last chunk did not reach parity step");

endmodule

`default_nettype wire

// ===== rtl/spnpuf_box_bank.sv =====
// ----------------------------------------------------------------------------
// spnpuf_box_bank
// Five 32-entry box memories: one write port, one registered read per box.
// ----------------------------------------------------------------------------
`default_nettype none

module spnpuf_box_bank
  import spnpuf_pkg::*;
#(
  parameter int W = 5
) (
  input  wire logic                    clk,
  input  wire box_wr_t                 wr,
  input  wire logic                    rd_en,
  input  wire grp_t                    rd_addr,
  output logic [NBOX-1:0][W-1:0]       rd_data
);

  localparam int DEPTH = 1 << GW;

  logic [W-1:0]            mem_r [NBOX][DEPTH];
  logic [NBOX-1:0][W-1:0]  rd_q_r;

  always_ff @(posedge clk) begin
    for (int b = 0; b < NBOX; b++) begin
      if (wr.en && wr.box == BOX_W'(b)) begin
        mem_r[b][wr.idx] <= wr.data[W-1:0];
      end
      // read before write: same-edge read returns the old entry
      if (rd_en) begin
        rd_q_r[b] <= mem_r[b][rd_addr[b]];
      end
    end
  end

  assign rd_data = rd_q_r;

endmodule

`default_nettype wire
